// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/core/hcb_pkg.sv -----
package hcb_pkg;
   localparam int CfgIdxWidth = 3;
   localparam int CfgWidth    = 32;
   localparam int AngFrac     = 30;
   localparam int AngWidth    = 36;
   localparam int CordicSteps = 30;
   localparam int StepWidth   = 5;
   localparam int ScaleDiv    = 100000;

   localparam logic [CfgIdxWidth-1:0] REG_MAP_OFFSET  = 3'd0;
   localparam logic [CfgIdxWidth-1:0] REG_MAP_DAMPING = 3'd1;
   localparam logic [CfgIdxWidth-1:0] REG_KEY_NEWEST  = 3'd2;
   localparam logic [CfgIdxWidth-1:0] REG_KEY_MIDDLE  = 3'd3;
   localparam logic [CfgIdxWidth-1:0] REG_KEY_OLDEST  = 3'd4;

   localparam logic signed [AngWidth-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [AngWidth-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [AngWidth-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [AngWidth-1:0] CORDIC_K    = 36'sd652032874;
   localparam logic signed [AngWidth-1:0] ONE_Q30     = 36'sd1073741824;
   localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C234;

   // Datapath commands issued by the controller.
   typedef struct packed {
      logic load_item;   // capture input byte, reload keys on restart
      logic prep;        // form half difference
      logic reduce_step; // one conditional subtract or add of a period multiple
      logic fold;        // fold angle and seed CORDIC
      logic rotate;      // one CORDIC iteration
      logic box;         // quantize, encrypt, latch result, load offset
      logic mul_sq;      // x1*x1 product
      logic mul_bx;      // b*x2 product; subtract the rounded x1*x1
      logic update;      // sum, saturate, shift the state
   } hcb_cmd_type;

   typedef struct packed {
      logic reduce_done;
      logic rotate_done;
   } hcb_stat_type;

   function automatic logic signed [AngWidth-1:0] atan_q30(input logic [StepWidth-1:0] i);
      logic signed [AngWidth-1:0] v;
      case (i)
         5'd0: v = 36'sd843314857;
         5'd1: v = 36'sd497837829;
         5'd2: v = 36'sd263043837;
         5'd3: v = 36'sd133525159;
         5'd4: v = 36'sd67021687;
         5'd5: v = 36'sd33543516;
         5'd6: v = 36'sd16775851;
         5'd7: v = 36'sd8388437;
         5'd8: v = 36'sd4194283;
         5'd9: v = 36'sd2097149;
         default: v = 36'sd1 <<< (AngFrac - i);
      endcase
      return v;
   endfunction

   function automatic logic [7:0] key_byte(input logic [3:0] k);
      logic [7:0] v;
      case (k)
         4'd0: v = 8'd1;
         4'd1: v = 8'd7;
         4'd2: v = 8'd49;
         4'd3: v = 8'd88;
         4'd4: v = 8'd106;
         4'd5: v = 8'd232;
         4'd6: v = 8'd94;
         4'd7: v = 8'd148;
         4'd8: v = 8'd16;
         4'd9: v = 8'd112;
         4'd10: v = 8'd19;
         default: v = 8'd1;
      endcase
      return v;
   endfunction

   // Output bit 7-j takes bit 7-p[j], p = 7,5,4,6,3,1,2,0.
   function automatic logic [7:0] permute(input logic [7:0] m);
      return {m[0], m[2], m[3], m[1], m[4], m[6], m[5], m[7]};
   endfunction
endpackage

// ----- rtl/core/hcb_ctrl.sv -----
module hcb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  hcb_pkg::hcb_stat_type stat,
   output hcb_pkg::hcb_cmd_type  cmd
);
   import hcb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_REDUCE, ST_FOLD, ST_ROTATE, ST_BOX,
      ST_MUL_SQ, ST_MUL_BX, ST_UPDATE, ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Step through one byte; the result waits in ST_HOLD only if the prior beat is unread.
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            cmd.load_item = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            if (stat.reduce_done) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (stat.rotate_done) state_in = ST_HOLD;
         end
         ST_HOLD: if (!rsp_valid_in) begin
            cmd.box = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_MUL_SQ;
         end
         ST_MUL_SQ: begin
            cmd.mul_sq = 1'b1;
            state_in = ST_MUL_BX;
         end
         ST_MUL_BX: begin
            cmd.mul_bx = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_IDLE;
         end
         ST_BOX: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
endmodule

// ----- rtl/core/hcb_datapath.sv -----
module hcb_datapath #(
   parameter int STATE_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic                   clock,
   input  logic [7:0]             plain_byte,
   input  logic                   restart,
   input  logic signed [hcb_pkg::CfgWidth-1:0] map_offset,
   input  logic signed [hcb_pkg::CfgWidth-1:0] map_damping,
   input  logic signed [hcb_pkg::CfgWidth-1:0] key_newest,
   input  logic signed [hcb_pkg::CfgWidth-1:0] key_middle,
   input  logic signed [hcb_pkg::CfgWidth-1:0] key_oldest,
   input  logic                   state_reload,
   input  hcb_pkg::hcb_cmd_type   cmd,
   output hcb_pkg::hcb_stat_type  stat,
   output logic [7:0]             cipher_byte,
   output logic [3:0]             box_number
);
   import hcb_pkg::*;

   localparam int W  = STATE_WIDTH;
   localparam int HW = W + 1;
   localparam int PW = 2 * W + 2;
   localparam int SW = 2 * W + 4;
   localparam logic [63:0] PER64 = TWO_PI_Q61 >> (61 - FRAC_BITS);
   localparam int CW = 64;
   localparam logic signed [HW-1:0] PER = HW'(PER64);
   localparam int RedSteps = W + 1 - (FRAC_BITS + 3) > 0 ? W + 1 - (FRAC_BITS + 3) + 2 : 2;
   localparam int RedWidth = $clog2(RedSteps + 1);
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] sat_reg(input logic signed [CfgWidth-1:0] r);
      logic signed [CW-1:0] v;
      v = CW'(r);
      if (v > CW'(SMAX)) return SMAX;
      if (v < CW'(SMIN)) return SMIN;
      return W'(v);
   endfunction

   logic signed [W-1:0]   x0_ff, x1_ff, x2_ff;
   logic [7:0]            plain_ff;
   logic signed [HW-1:0]  r_ff;
   logic [RedWidth-1:0]   red_cnt_ff;
   logic signed [AngWidth-1:0] cx_ff, cy_ff, cz_ff;
   logic [StepWidth-1:0]  step_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [SW-1:0]  acc_ff;
   logic [7:0]            cipher_ff;
   logic [3:0]            box_ff;

   // Period reduction: subtract (add, if negative) the largest multiple first, down to the period itself.
   logic [RedWidth-1:0]   shift_amt;
   logic signed [HW+RedSteps-1:0] per_sh, r_wide;
   assign shift_amt = RedWidth'(RedSteps - 2) - red_cnt_ff;
   assign per_sh = (HW+RedSteps)'(PER) <<< shift_amt;
   assign r_wide = (HW+RedSteps)'(r_ff);

   // Fold angle to [-pi/2, pi/2].
   logic signed [AngWidth+W-1:0] t_full;
   logic signed [AngWidth-1:0]   t0, t1, t2;
   always_comb begin
      if (FRAC_BITS >= AngFrac) t_full = (AngWidth+W)'(r_ff) >>> (FRAC_BITS - AngFrac);
      else t_full = (AngWidth+W)'(r_ff) <<< (AngFrac - FRAC_BITS);
      t0 = AngWidth'(t_full);
      t1 = (t0 > PI_Q30) ? t0 - TWO_PI_Q30 : t0;
      if (t1 > HALF_PI_Q30) t2 = PI_Q30 - t1;
      else if (t1 < -HALF_PI_Q30) t2 = -PI_Q30 - t1;
      else t2 = t1;
   end

   // One CORDIC iteration.
   logic signed [AngWidth-1:0] dx, dy;
   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;

   // Quantize and encrypt.
   logic [3:0] box_q;
   logic signed [AngWidth+3:0] scaled;
   logic [7:0] cipher_q;
   always_comb begin
      scaled = (AngWidth+4)'(5) * ((AngWidth+4)'(cy_ff < -ONE_Q30 ? -ONE_Q30 : cy_ff)
               + (AngWidth+4)'(ONE_Q30));
      if (cy_ff >= ONE_Q30) box_q = 4'd0;
      else box_q = 4'd1 + 4'(scaled >>> AngFrac);
      cipher_q = permute(plain_ff ^ key_byte(box_q));
   end

   // Feedback term round(c * 2^F / 100000), looked up by cipher byte in a constant table.
   logic [FRAC_BITS+8:0] fb_table [256];
   logic [FRAC_BITS+8:0] fb_q;
   for (genvar c = 0; c < 256; c++) begin : g_fb_table
      assign fb_table[c] = (FRAC_BITS+9)'(((128'(c) << FRAC_BITS) + 128'(ScaleDiv / 2))
                                          / 128'(ScaleDiv));
   end
   assign fb_q = fb_table[cipher_ff];

   logic signed [PW-1:0] rnd;
   assign rnd = (prod_ff + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

   // Subtract the rounded b*x2 product and add the feedback, then saturate to the state width.
   logic signed [SW-1:0] acc_fin;
   logic signed [W-1:0] next_x0;
   assign acc_fin = acc_ff - SW'(rnd) + SW'(fb_q);
   assign next_x0 = (acc_fin > SW'(SMAX)) ? SMAX : (acc_fin < SW'(SMIN)) ? SMIN : W'(acc_fin);

   always_ff @(posedge clock) begin
      if (state_reload) begin
         x0_ff <= sat_reg(key_newest);
         x1_ff <= sat_reg(key_middle);
         x2_ff <= sat_reg(key_oldest);
      end else if (cmd.load_item && restart) begin
         x0_ff <= sat_reg(key_newest);
         x1_ff <= sat_reg(key_middle);
         x2_ff <= sat_reg(key_oldest);
      end else if (cmd.update) begin
         x2_ff <= x1_ff;
         x1_ff <= x0_ff;
         x0_ff <= next_x0;
      end
      if (cmd.load_item) plain_ff <= plain_byte;
      if (cmd.prep) begin
         r_ff <= (HW'(x1_ff) - HW'(x2_ff)) >>> 1;
         red_cnt_ff <= '0;
      end
      if (cmd.reduce_step) begin
         if (red_cnt_ff == RedWidth'(RedSteps - 1)) begin
            if (r_ff < 0) r_ff <= r_ff + PER;
         end else if (r_ff < 0) begin
            if (r_wide + per_sh <= 0) r_ff <= HW'(r_wide + per_sh);
         end else if (r_wide >= per_sh) r_ff <= HW'(r_wide - per_sh);
         red_cnt_ff <= red_cnt_ff + 1'b1;
      end
      if (cmd.fold) begin
         cx_ff <= CORDIC_K;
         cy_ff <= '0;
         cz_ff <= t2;
         step_ff <= '0;
      end
      if (cmd.rotate) begin
         if (cz_ff >= 0) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_q30(step_ff);
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_q30(step_ff);
         end
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.box) begin
         box_ff <= box_q;
         cipher_ff <= cipher_q;
         acc_ff <= SW'(sat_reg(map_offset));
      end
      if (cmd.mul_sq) prod_ff <= PW'(x1_ff) * PW'(x1_ff);
      if (cmd.mul_bx) begin
         prod_ff <= PW'(sat_reg(map_damping)) * PW'(x2_ff);
         acc_ff <= acc_ff - SW'(rnd);
      end
   end

   assign stat.reduce_done = (red_cnt_ff == RedWidth'(RedSteps - 1));
   assign stat.rotate_done = (step_ff == StepWidth'(CordicSteps - 1));
   assign cipher_byte = cipher_ff;
   assign box_number  = box_ff;
endmodule

// ----- rtl/core/henon3d_chaotic_byte_cipher.sv -----
// Channel  Ports                Beat contents (low bit up)
// req      req_tvalid/tready    tdata: plain_byte[7:0]; tuser: restart
// rsp      rsp_tvalid/tready    tdata: cipher_byte[7:0], box_number[11:8], zero fill
// csr      csr_valid/ready      csr_index register number, csr_data value
// A byte runs R period reduction steps, R = STATE_WIDTH - FRAC_BITS (at least 2), then
// the 30 step CORDIC rotation; the next byte is accepted only after the state update.
// The result beat is raised by the box step and held until it is read.
// Reset is synchronous; the map state loads from the key registers, all zero.
// An unread result holds the next byte before its box step; input waits in idle.
`include "assert_macros.svh"
module henon3d_chaotic_byte_cipher #(
   parameter int STATE_WIDTH = 32,
   parameter int FRAC_BITS   = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // plain_byte
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cipher_byte[7:0], box_number[11:8]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [hcb_pkg::CfgIdxWidth-1:0] csr_index,
   input  logic [hcb_pkg::CfgWidth-1:0]    csr_data
);
   import hcb_pkg::*;

   logic [CfgWidth-1:0] offset_ff, damping_ff, kn_ff, km_ff, ko_ff;
   logic                reload_ff;
   hcb_cmd_type         cmd;
   hcb_stat_type        stat;
   logic [7:0]          cipher;
   logic [3:0]          box;

   // Hold the register file; reload the map state from the keys after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0; damping_ff <= '0;
         kn_ff <= '0; km_ff <= '0; ko_ff <= '0;
         reload_ff <= 1'b1;
      end else begin
         reload_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               REG_MAP_OFFSET:  offset_ff  <= csr_data;
               REG_MAP_DAMPING: damping_ff <= csr_data;
               REG_KEY_NEWEST:  kn_ff      <= csr_data;
               REG_KEY_MIDDLE:  km_ff      <= csr_data;
               REG_KEY_OLDEST:  ko_ff      <= csr_data;
               default: ;
            endcase
         end
      end
   end
   assign csr_ready = 1'b1;

   hcb_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd
   );

   hcb_datapath #(.STATE_WIDTH(STATE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .plain_byte(req_tdata), .restart(req_tuser),
      .map_offset(offset_ff), .map_damping(damping_ff),
      .key_newest(kn_ff), .key_middle(km_ff), .key_oldest(ko_ff),
      .state_reload(reload_ff), .cmd, .stat, .cipher_byte(cipher), .box_number(box)
   );

   assign rsp_tdata = {4'd0, box, cipher};

   `ASSERT_IMPL(a_box_range, clock, reset, rsp_tvalid |-> rsp_tdata[11:8] <= 4'd10)
   `ASSERT_IMPL(a_one_cmd, clock, reset, $onehot0(cmd))
   `ASSERT_IMPL(a_rsp_from_box, clock, reset, $rose(rsp_tvalid) |-> $past(cmd.box))
endmodule

// ----- verif/tb_henon3d_chaotic_byte_cipher.sv -----
module tb_henon3d_chaotic_byte_cipher;
   timeunit 1ns;
   timeprecision 1ps;
   import hcb_pkg::*;

   localparam int STATE_WIDTH = 32;
   localparam int FRAC_BITS   = 28;
   localparam int DRAIN_CYCLES = 120;
   localparam int STALL_LIMIT  = 20000;
   localparam logic [CfgIdxWidth-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [3:0] box;
      logic [7:0] cipher;
   } cipher_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [CfgIdxWidth-1:0] csr_index;
   logic [CfgWidth-1:0]    csr_data;

   // shadow copy of the block's registers and chaotic state
   logic [31:0] shadow_regs [0:4];
   longint      x_newest, x_middle, x_oldest;

   cipher_beat_type expected_beats [$];
   int  mismatch_count;
   int  idle_cycles;
   bit  rsp_stall_enable;
   bit  rsp_hold_off;
   bit  req_stall_enable;

   henon3d_chaotic_byte_cipher #(
      .STATE_WIDTH(STATE_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint clamp_state(longint v);
      longint mx;
      mx = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
      if (v > mx) return mx;
      if (v < -mx - 1) return -mx - 1;
      return v;
   endfunction

   function automatic longint reg_state(logic [31:0] r);
      return clamp_state(longint'(signed'(r)));
   endfunction

   // product rounded half up by FRAC_BITS, exact in 128 bits
   function automatic logic signed [127:0] round_product(longint a, longint b);
      logic signed [127:0] p;
      p = 128'(signed'(a)) * 128'(signed'(b));
      p = p + (128'sd1 <<< (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic [3:0] sine_box(longint x1, longint x2);
      longint h, per, r, t, x, y, z, dx, dy;
      logic [63:0] two_pi;
      int sh;
      h = (x1 - x2) >>> 1;
      two_pi = TWO_PI_Q61;
      per = longint'(two_pi >> (61 - FRAC_BITS));
      r = h % per;
      if (r < 0) r += per;
      sh = FRAC_BITS - AngFrac;
      t = (sh >= 0) ? (r >>> sh) : (r <<< (-sh));
      if (t > 64'sd3373259426) t -= 64'sd6746518852;
      if (t > 64'sd1686629713) t = 64'sd3373259426 - t;
      else if (t < -64'sd1686629713) t = -64'sd3373259426 - t;
      x = 64'sd652032874;
      y = 0;
      z = t;
      for (int i = 0; i < CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
         end else begin
            x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
         end
      end
      if (y >= 64'sd1073741824) return 4'd0;
      if (y < -64'sd1073741824) y = -64'sd1073741824;
      return 4'(1 + ((5 * (y + 64'sd1073741824)) >>> AngFrac));
   endfunction

   function automatic longint feedback_term(logic [7:0] c);
      longint q, r;
      q = 0;
      r = c;
      for (int k = 0; k < FRAC_BITS; k++) begin
         q = q <<< 1;
         r = r <<< 1;
         if (r >= ScaleDiv) begin
            r -= ScaleDiv;
            q |= 1;
         end
      end
      if (2 * r >= ScaleDiv) q++;
      return q;
   endfunction

   function automatic cipher_beat_type encrypt_byte(logic [7:0] plain, logic restart);
      cipher_beat_type beat;
      logic [7:0] mixed;
      logic signed [127:0] acc, mx;
      if (restart) begin
         x_newest = reg_state(shadow_regs[REG_KEY_NEWEST]);
         x_middle = reg_state(shadow_regs[REG_KEY_MIDDLE]);
         x_oldest = reg_state(shadow_regs[REG_KEY_OLDEST]);
      end
      beat.box = sine_box(x_middle, x_oldest);
      mixed = plain ^ key_byte(beat.box);
      beat.cipher = {mixed[0], mixed[2], mixed[3], mixed[1],
                     mixed[4], mixed[6], mixed[5], mixed[7]};
      acc = 128'(signed'(reg_state(shadow_regs[REG_MAP_OFFSET])));
      acc = acc - round_product(x_middle, x_middle);
      acc = acc - round_product(reg_state(shadow_regs[REG_MAP_DAMPING]), x_oldest);
      acc = acc + 128'(signed'(feedback_term(beat.cipher)));
      mx = (128'sd1 <<< (STATE_WIDTH - 1)) - 1;
      if (acc > mx) acc = mx;
      else if (acc < -mx - 1) acc = -mx - 1;
      x_oldest = x_middle;
      x_middle = x_newest;
      x_newest = longint'(acc);
      return beat;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_byte(logic [7:0] plain, logic restart);
      cipher_beat_type beat;
      while (req_stall_enable && $urandom_range(99) < 20) @(posedge clock);
      beat = encrypt_byte(plain, restart);
      expected_beats.insert(expected_beats.size(), beat);
      req_tvalid <= 1'b1;
      req_tdata  <= plain;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // drop valid so the next beat starts on a later edge
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CfgIdxWidth-1:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index <= REG_KEY_OLDEST) shadow_regs[index] = value;
      @(posedge clock);
   endtask

   task automatic load_settings(logic [31:0] a, logic [31:0] b, logic [31:0] k0,
                                logic [31:0] k1, logic [31:0] k2);
      wait_drained();
      write_reg(REG_MAP_OFFSET, a);
      write_reg(REG_MAP_DAMPING, b);
      write_reg(REG_KEY_NEWEST, k0);
      write_reg(REG_KEY_MIDDLE, k1);
      write_reg(REG_KEY_OLDEST, k2);
   endtask

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      cipher_beat_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[11:0];
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat %h", rsp_tdata);
         end else begin
            want = expected_beats.pop_front();
            if (got.cipher !== want.cipher || got.box !== want.box
                || rsp_tdata[15:12] !== 4'd0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: cipher exp %h got %h, box exp %0d got %0d",
                           want.cipher, got.cipher, want.box, got.box);
            end
         end
      end
   end

   // receiver ready: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (rsp_hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= !(rsp_stall_enable && $urandom_range(99) < 20);
   end

   // watchdog on cycles without any beat accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reset_state();
      // keys all zero after reset: sine of zero lands in box 6
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);
   endtask

   task automatic test_field_extremes();
      load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   task automatic test_sine_boxes();
      // half difference near pi/2 (Q4.28 about 0x1921FB54) gives sine one: box 0
      load_settings(32'h1000_0000, 32'h0400_0000, 32'h0, 32'h3243_F6A8, 32'h0);
      send_byte(8'h3C, 1'b1);
      // near -pi/2 gives the lowest box
      load_settings(32'h1000_0000, 32'h0400_0000, 32'h0, 32'h0, 32'h3243_F6A8);
      send_byte(8'hC3, 1'b1);
      // a sweep of differences walks the boxes; ignored index in between
      wait_drained();
      write_reg(REG_UNUSED, 32'hDEAD_BEEF);
      for (int k = 0; k < 12; k++) begin
         write_reg(REG_KEY_MIDDLE, 32'(k * 32'h0090_0000) - 32'h0600_0000);
         send_byte(8'(k * 23), 1'b1);
         wait_drained();
      end
   endtask

   task automatic test_random_stream(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 0) begin
            load_settings($urandom_range(1) ? 32'h1666_6666 + $urandom_range(32'h0FFF_FFFF)
                                            : $urandom(),
                          $urandom_range(1) ? 32'h04CC_CCCD : $urandom(),
                          $urandom(), $urandom(), $urandom());
         end
         req_stall_enable = (n % 300) < 200;
         rsp_stall_enable = (n % 300) < 200;
         send_byte(8'($urandom()), $urandom_range(99) < 5);
      end
   endtask

   task automatic test_back_pressure();
      // receiver holds off while the sender keeps offering bytes
      fork
         begin
            rsp_hold_off = 1'b1;
            repeat (600) @(posedge clock);
            rsp_hold_off = 1'b0;
         end
         for (int n = 0; n < 20; n++) send_byte(8'($urandom()), 1'b0);
      join
      // sender pauses until every result has come
      while (expected_beats.size() != 0) @(posedge clock);
      for (int n = 0; n < 10; n++) send_byte(8'($urandom()), n == 0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_tready = 1'b0;
      rsp_hold_off = 1'b0;
      rsp_stall_enable = 1'b1;
      req_stall_enable = 1'b1;
      mismatch_count = 0;
      idle_cycles = 0;
      for (int i = 0; i <= 4; i++) shadow_regs[i] = '0;
      x_newest = 0;
      x_middle = 0;
      x_oldest = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_field_extremes();
      test_sine_boxes();
      test_back_pressure();
      test_random_stream(1050);
      wait_drained();

      if (mismatch_count == 0 && expected_beats.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/hcb_pkg.sv
rtl/core/hcb_ctrl.sv
rtl/core/hcb_datapath.sv
rtl/core/henon3d_chaotic_byte_cipher.sv
verif/tb_henon3d_chaotic_byte_cipher.sv
